[src/lpe_pkg.sv]
`default_nettype none

package lpe_pkg;

    // field widths
    localparam int SAMPLE_W = 12;
    localparam int POS_W    = 6;
    localparam int SCALED_W = 11;   // floor(4095*10/33) = 1240
    localparam int WEIGHT_W = 6;    // 7*5 = 35
    localparam int SUM_W    = 18;   // weighted sum up to 173600
    localparam int TOT_W    = 14;   // weight total up to 9920
    localparam int NUM_SENS = 8;

    // register file
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;
    localparam logic [0:0] REG_LINE_THR  = 1'b0;
    localparam logic [0:0] REG_NOISE_THR = 1'b1;
    localparam logic [SAMPLE_W-1:0] LINE_THR_RST  = 12'd2000;
    localparam logic [SAMPLE_W-1:0] NOISE_THR_RST = 12'd600;

    // s*10/33 as a reciprocal multiply: floor(s * 10 * ceil(2^21/33) / 2^21)
    localparam int SCALE_SHIFT = 21;
    localparam int PROD_W      = 32;
    localparam logic [19:0] SCALE_MUL = 20'd635510;

    // fallback positions
    localparam logic [POS_W-1:0] CENTER_MARK = 6'd17;
    localparam logic [POS_W-1:0] RIGHT_EDGE  = 6'd40;
    localparam logic [POS_W-1:0] LEFT_EDGE   = 6'd0;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample_0;
        logic [SAMPLE_W-1:0] sample_1;
        logic [SAMPLE_W-1:0] sample_2;
        logic [SAMPLE_W-1:0] sample_3;
        logic [SAMPLE_W-1:0] sample_4;
        logic [SAMPLE_W-1:0] sample_5;
        logic [SAMPLE_W-1:0] sample_6;
        logic [SAMPLE_W-1:0] sample_7;
    } t_in_beat;

    typedef struct packed {
        logic [POS_W-1:0] position;
        logic             on_line;
    } t_out_beat;

    // divider request and status
    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] dividend;
        logic [TOT_W-1:0] divisor;
    } t_div_ctl;

    typedef struct packed {
        logic             done;
        logic [POS_W-1:0] quot;
    } t_div_stat;

endpackage

`default_nettype wire

[src/lpe_div.sv]
`default_nettype none

// Restoring divider, one quotient bit per cycle. The quotient is known to
// fit in POS_W bits, so only that many steps are run.
module lpe_div (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire lpe_pkg::t_div_ctl i_ctl,
    output lpe_pkg::t_div_stat     o_stat
);
    import lpe_pkg::*;

    localparam int BIT_W = $clog2(POS_W);
    localparam int CMP_W = SUM_W + 2;

    logic             r_busy;
    logic             r_done;
    logic [BIT_W-1:0] r_bit;
    logic [SUM_W-1:0] r_rem;
    logic [TOT_W-1:0] r_div;
    logic [POS_W-1:0] r_quot;

    logic [CMP_W-1:0] cand;
    logic [CMP_W-1:0] rem_ext;
    logic [CMP_W-1:0] diff;
    logic             ge;

    // trial subtract of the shifted divisor
    always_comb begin
        cand    = {{(CMP_W-TOT_W){1'b0}}, r_div} << r_bit;
        rem_ext = {{(CMP_W-SUM_W){1'b0}}, r_rem};
        diff    = rem_ext - cand;
        ge      = (rem_ext >= cand);
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_bit  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_bit  <= BIT_W'(POS_W - 1);
            end else if (r_busy) begin
                if (r_bit == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_bit <= r_bit - 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_rem  <= i_ctl.dividend;
            r_div  <= i_ctl.divisor;
            r_quot <= '0;
        end else if (r_busy) begin
            if (ge) begin
                r_rem <= diff[SUM_W-1:0];
            end
            r_quot[r_bit] <= ge;
        end
    end

    assign o_stat.done = r_done;
    assign o_stat.quot = r_quot;

endmodule

`default_nettype wire

[src/line_position_estimator.sv]
`default_nettype none

// Channel   Direction  Handshake                 Payload
// in        sink       i_in_valid / o_in_stall   i_in_beat  (t_in_beat)
// out       source     o_out_valid / i_out_stall o_out_beat (t_out_beat)
// cfg       APB slave  psel penable pwrite pready paddr pwdata prdata
//
// A frame passes from accept to result through the shared scale/weight accumulator
// (one sensor per cycle plus a pipeline flush), a check, the restoring divider
// (6 steps and a done cycle) and the load of the output register; the divide
// is skipped when the weight total is zero. The input is stalled while a frame
// is in work, so no new frame is taken until the last is in the output register;
// the output register holds one result, so the next frame is taken while it waits.
// Reset is synchronous and active low; it restores both thresholds and
// clears the last position.
module line_position_estimator (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // input frames
    input  wire logic                   i_in_valid,
    output logic                        o_in_stall,
    input  wire lpe_pkg::t_in_beat      i_in_beat,
    // results
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output lpe_pkg::t_out_beat          o_out_beat,
    // config
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [lpe_pkg::PADDR_W-1:0] paddr,
    input  wire logic [lpe_pkg::PDATA_W-1:0] pwdata,
    output logic [lpe_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);
    import lpe_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ACC  = 3'd1;
    localparam logic [2:0] S_CHK  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    localparam int CNT_W = $clog2(NUM_SENS) + 1;
    localparam int IDX_W = $clog2(NUM_SENS);

    logic [2:0]          r_state;
    logic [CNT_W-1:0]    r_cnt;
    t_in_beat            r_samp;
    logic                r_seen;
    logic [SCALED_W-1:0] r_sc;
    logic [WEIGHT_W-1:0] r_wt;
    logic [SUM_W-1:0]    r_sum;
    logic [TOT_W-1:0]    r_tot;
    logic [POS_W-1:0]    r_pos;
    logic [POS_W-1:0]    r_last;
    logic [SAMPLE_W-1:0] r_line_thr;
    logic [SAMPLE_W-1:0] r_noise_thr;
    logic                r_out_valid;
    t_out_beat           r_out;

    logic                in_acc;
    logic                out_free;
    logic                cfg_wr;
    logic [IDX_W-1:0]    idx;
    logic                in_range;
    logic [SAMPLE_W-1:0] cur;
    logic [PROD_W-1:0]   prod;
    logic [SCALED_W-1:0] scaled;
    logic [WEIGHT_W-1:0] weight;
    logic [SCALED_W+WEIGHT_W-1:0] wprod;
    logic [POS_W-1:0]    fallback;
    t_div_ctl            div_ctl;
    t_div_stat           div_stat;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign cfg_wr   = psel && penable && pwrite && pready;

    // sensor select
    assign idx      = r_cnt[IDX_W-1:0];
    assign in_range = (r_cnt < CNT_W'(NUM_SENS));
    always_comb begin
        case (idx)
            3'd0:    cur = r_samp.sample_0;
            3'd1:    cur = r_samp.sample_1;
            3'd2:    cur = r_samp.sample_2;
            3'd3:    cur = r_samp.sample_3;
            3'd4:    cur = r_samp.sample_4;
            3'd5:    cur = r_samp.sample_5;
            3'd6:    cur = r_samp.sample_6;
            default: cur = r_samp.sample_7;
        endcase
    end

    // scale by 10/33 via reciprocal, weight = index*5
    assign prod   = PROD_W'(cur) * PROD_W'(SCALE_MUL);
    assign scaled = prod[SCALE_SHIFT +: SCALED_W];
    assign weight = {1'b0, idx, 2'b00} + WEIGHT_W'(idx);
    assign wprod  = (SCALED_W+WEIGHT_W)'(r_sc) * (SCALED_W+WEIGHT_W)'(r_wt);

    // position when the weight total is zero
    always_comb begin
        if (r_seen) begin
            fallback = r_last;
        end else if (r_last < CENTER_MARK) begin
            fallback = LEFT_EDGE;
        end else begin
            fallback = RIGHT_EDGE;
        end
    end

    assign div_ctl.start    = (r_state == S_CHK) && (r_tot != '0);
    assign div_ctl.dividend = r_sum;
    assign div_ctl.divisor  = r_tot;

    lpe_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (div_ctl),
        .o_stat  (div_stat)
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_last      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // output beat: load wins over drain
            if ((r_state == S_FIN) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_cnt   <= '0;
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(NUM_SENS)) begin
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    r_state <= (r_tot != '0) ? S_DIV : S_FIN;
                end
                S_DIV: begin
                    if (div_stat.done) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_last  <= r_pos;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // accumulator and result datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_samp <= i_in_beat;
                    r_seen <= 1'b0;
                    r_sc   <= '0;
                    r_wt   <= '0;
                    r_sum  <= '0;
                    r_tot  <= '0;
                end
            end
            S_ACC: begin
                if (in_range && (cur > r_line_thr)) begin
                    r_seen <= 1'b1;
                end
                r_sc  <= (in_range && (cur > r_noise_thr)) ? scaled : '0;
                r_wt  <= weight;
                r_sum <= r_sum + SUM_W'(wprod);
                r_tot <= r_tot + TOT_W'(r_sc);
            end
            S_CHK: begin
                r_pos <= fallback;
            end
            S_DIV: begin
                if (div_stat.done) begin
                    r_pos <= div_stat.quot;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    r_out.position <= r_pos;
                    r_out.on_line  <= r_seen;
                end
            end
            default: ;
        endcase
    end

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_thr  <= LINE_THR_RST;
            r_noise_thr <= NOISE_THR_RST;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_LINE_THR:  r_line_thr  <= pwdata[SAMPLE_W-1:0];
                REG_NOISE_THR: r_noise_thr <= pwdata[SAMPLE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_LINE_THR:  prdata = PDATA_W'(r_line_thr);
            REG_NOISE_THR: prdata = PDATA_W'(r_noise_thr);
            default:       prdata = '0;
        endcase
    end

    assign pready      = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

endmodule

`default_nettype wire
